// ----- hw/rtl/hq_pkg.sv -----
// ----------------------------------------------------------------------------
// hq_pkg: shared types and constants
// Entry, channel payload, controller command and datapath status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hq_pkg;

  localparam int CAPACITY     = 64;
  localparam int HANDLE_COUNT = 256;

  localparam logic [6:0] CAP_CNT = 7'd64;

  localparam logic       CMD_INSERT = 1'b0;
  localparam logic       CMD_DELETE = 1'b1;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  localparam logic [1:0] KIND_UNORDERED = 2'd3;

  typedef struct packed {
    logic [51:0] key;     // {sec, usec}
    logic [7:0]  handle;
  } entry_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  handle;
    logic [31:0] key_sec;
    logic [19:0] key_usec;
    logic [5:0]  position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic        top_valid;
    logic [7:0]  top_handle;
    logic [31:0] top_key_sec;
    logic [19:0] top_key_usec;
    logic [5:0]  handle_position;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS,
    OP_FULL,
    OP_BAD,
    OP_SHRINK,
    OP_RD_LAST,
    OP_MOVE,
    OP_SU_RD,
    OP_CAPB,
    OP_RB_INIT,
    OP_RB_NEXT,
    OP_RD_CUR,
    OP_CAPA_RDCHD,
    OP_CAPB_RDR,
    OP_CAPC,
    OP_PICK,
    OP_SW1,
    OP_SW2,
    OP_RD_TOP,
    OP_FIN
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_RDLAST,
    ST_MOVE,
    ST_RBINIT,
    ST_RBNEXT,
    ST_SDCHK,
    ST_SDA,
    ST_SDB,
    ST_SDC,
    ST_SDPICK,
    ST_SDCMP,
    ST_DSW1,
    ST_DSW2,
    ST_SUCHK,
    ST_SUCAP,
    ST_SUCMP,
    ST_USW1,
    ST_USW2,
    ST_RDTOP,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic is_del;
    logic full;
    logic pos_bad;
    logic pos_last;
    logic cur_zero;
    logic cnt_lt2;
    logic idx_zero;
    logic chd_gt_last;
    logic chd_lt_last;
    logic up_stop;
    logic dn_stop;
    logic out_busy;
  } flags_t;

endpackage

// ----- hw/rtl/hq_stream_if.sv -----
// ----------------------------------------------------------------------------
// hq_stream_if: valid/ready channel
// Carries one payload beat per valid and ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/hq_dpath.sv -----
// ----------------------------------------------------------------------------
// hq_dpath: heap datapath
// Slot memory, handle map, work registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hq_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     kind_i,
  input  hq_pkg::op_e    op_i,
  input  hq_pkg::req_t   item_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output hq_pkg::rsp_t   out_o,
  output hq_pkg::flags_t flags_o
);

  hq_pkg::entry_t slot_mem [hq_pkg::CAPACITY];
  logic [5:0]     map_mem  [hq_pkg::HANDLE_COUNT];
  logic [hq_pkg::HANDLE_COUNT-1:0] map_vld_q;

  logic           cmd_q;
  logic [7:0]     hnd_q;
  logic [51:0]    nkey_q;
  logic [5:0]     pos_q;
  logic [6:0]     cnt_q;
  logic [5:0]     cur_q, oth_q, idx_q;
  logic [6:0]     chd_q;
  logic [1:0]     sts_q;
  hq_pkg::entry_t a_q, b_q, c_q, rd_q;
  logic [5:0]     map_rd_q;
  logic           out_valid_q;
  hq_pkg::rsp_t   out_q;

  logic           unord;
  logic [6:0]     last;
  logic [5:0]     par;
  logic [6:0]     chd_p1;
  logic [5:0]     idx_m1;
  logic [6:0]     idx_init;

  logic           re, we, mwe;
  logic [5:0]     raddr, waddr, mwd;
  logic [7:0]     mwa;
  hq_pkg::entry_t wdata;

  assign unord    = (kind_i == hq_pkg::KIND_UNORDERED);
  assign last     = cnt_q - 7'd1;
  assign par      = (cur_q - 6'd1) >> 1;
  assign chd_p1   = chd_q + 7'd1;
  assign idx_m1   = idx_q - 6'd1;
  assign idx_init = ((cnt_q - 7'd2) >> 1) + 7'd1;

  always_comb begin
    flags_o.is_del      = (cmd_q == hq_pkg::CMD_DELETE);
    flags_o.full        = (cnt_q == hq_pkg::CAP_CNT);
    flags_o.pos_bad     = ({1'b0, pos_q} >= cnt_q);
    flags_o.pos_last    = ({1'b0, pos_q} == last);
    flags_o.cur_zero    = (cur_q == 6'd0);
    flags_o.cnt_lt2     = (cnt_q < 7'd2);
    flags_o.idx_zero    = (idx_q == 6'd0);
    flags_o.chd_gt_last = (chd_q > last);
    flags_o.chd_lt_last = (chd_q < last);
    flags_o.up_stop     = unord || (b_q.key < a_q.key);
    flags_o.dn_stop     = unord || (a_q.key < b_q.key);
    flags_o.out_busy    = out_valid_q && !out_ready_i;
  end

  // memory port decode
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = a_q;
    mwe   = 1'b0;
    mwa   = a_q.handle;
    mwd   = '0;
    case (op_i)
      hq_pkg::OP_INS: begin
        we    = 1'b1;
        waddr = cnt_q[5:0];
        wdata = '{key: nkey_q, handle: hnd_q};
        mwe   = 1'b1;
        mwa   = hnd_q;
        mwd   = cnt_q[5:0];
      end
      hq_pkg::OP_RD_LAST: begin
        re    = 1'b1;
        raddr = last[5:0];
      end
      hq_pkg::OP_MOVE: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = rd_q;
        mwe   = 1'b1;
        mwa   = rd_q.handle;
        mwd   = pos_q;
      end
      hq_pkg::OP_SU_RD: begin
        re    = 1'b1;
        raddr = par;
      end
      hq_pkg::OP_RD_CUR: begin
        re    = 1'b1;
        raddr = cur_q;
      end
      hq_pkg::OP_CAPA_RDCHD: begin
        re    = 1'b1;
        raddr = chd_q[5:0];
      end
      hq_pkg::OP_CAPB_RDR: begin
        re    = 1'b1;
        raddr = chd_p1[5:0];
      end
      hq_pkg::OP_SW1: begin
        we    = 1'b1;
        waddr = cur_q;
        wdata = b_q;
        mwe   = 1'b1;
        mwa   = b_q.handle;
        mwd   = cur_q;
      end
      hq_pkg::OP_SW2: begin
        we    = 1'b1;
        waddr = oth_q;
        wdata = a_q;
        mwe   = 1'b1;
        mwa   = a_q.handle;
        mwd   = oth_q;
      end
      hq_pkg::OP_RD_TOP: begin
        re    = 1'b1;
        raddr = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= slot_mem[raddr];
    end
  end

  // map entries not yet written read as slot zero
  always_ff @(posedge clk_i) begin
    if (mwe) begin
      map_mem[mwa] <= mwd;
    end
    if (op_i == hq_pkg::OP_RD_TOP) begin
      map_rd_q <= map_vld_q[hnd_q] ? map_mem[hnd_q] : 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
    end else if (mwe) begin
      map_vld_q[mwa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i)
        hq_pkg::OP_INS:    cnt_q <= cnt_q + 7'd1;
        hq_pkg::OP_SHRINK: cnt_q <= last;
        hq_pkg::OP_MOVE:   cnt_q <= last;
        default: begin
        end
      endcase
      if (op_i == hq_pkg::OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      hq_pkg::OP_LOAD: begin
        cmd_q  <= item_i.cmd;
        hnd_q  <= item_i.handle;
        nkey_q <= {item_i.key_sec, item_i.key_usec};
        pos_q  <= item_i.position;
      end
      hq_pkg::OP_INS: begin
        a_q   <= '{key: nkey_q, handle: hnd_q};
        cur_q <= cnt_q[5:0];
        sts_q <= hq_pkg::STS_OK;
      end
      hq_pkg::OP_FULL:   sts_q <= hq_pkg::STS_FULL;
      hq_pkg::OP_BAD:    sts_q <= hq_pkg::STS_RANGE;
      hq_pkg::OP_SHRINK: sts_q <= hq_pkg::STS_OK;
      hq_pkg::OP_MOVE:   sts_q <= hq_pkg::STS_OK;
      hq_pkg::OP_SU_RD:  oth_q <= par;
      hq_pkg::OP_CAPB:   b_q   <= rd_q;
      hq_pkg::OP_RB_INIT: idx_q <= idx_init[5:0];
      hq_pkg::OP_RB_NEXT: begin
        cur_q <= idx_m1;
        chd_q <= {idx_m1, 1'b1};
        idx_q <= idx_m1;
      end
      hq_pkg::OP_CAPA_RDCHD: begin
        a_q   <= rd_q;
        oth_q <= chd_q[5:0];
      end
      hq_pkg::OP_CAPB_RDR: b_q <= rd_q;
      hq_pkg::OP_CAPC:     c_q <= rd_q;
      hq_pkg::OP_PICK: begin
        // right child wins when strictly smaller, or always in unordered mode
        if (unord || (c_q.key < b_q.key)) begin
          b_q   <= c_q;
          oth_q <= chd_p1[5:0];
        end
      end
      hq_pkg::OP_SW2: begin
        cur_q <= oth_q;
        chd_q <= {oth_q, 1'b1};
      end
      hq_pkg::OP_FIN: begin
        out_q.status          <= sts_q;
        out_q.count           <= cnt_q;
        out_q.top_valid       <= (cnt_q != 7'd0);
        out_q.top_handle      <= (cnt_q != 7'd0) ? rd_q.handle : 8'd0;
        out_q.top_key_sec     <= (cnt_q != 7'd0) ? rd_q.key[51:20] : 32'd0;
        out_q.top_key_usec    <= (cnt_q != 7'd0) ? rd_q.key[19:0] : 20'd0;
        out_q.handle_position <= map_rd_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- hw/rtl/hq_ctrl.sv -----
// ----------------------------------------------------------------------------
// hq_ctrl: heap sequencer
// Steps insert sift-up, delete with bottom-up rebuild, and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  hq_pkg::flags_t flags_i,
  output logic           in_ready_o,
  output hq_pkg::op_e    op_o
);

  hq_pkg::st_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hq_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      hq_pkg::ST_IDLE:   if (in_valid_i) st_d = hq_pkg::ST_DISP;
      hq_pkg::ST_DISP: begin
        if (!flags_i.is_del) begin
          st_d = flags_i.full ? hq_pkg::ST_RDTOP : hq_pkg::ST_SUCHK;
        end else if (flags_i.pos_bad || flags_i.pos_last) begin
          st_d = hq_pkg::ST_RDTOP;
        end else begin
          st_d = hq_pkg::ST_RDLAST;
        end
      end
      hq_pkg::ST_RDLAST: st_d = hq_pkg::ST_MOVE;
      hq_pkg::ST_MOVE:   st_d = hq_pkg::ST_RBINIT;
      hq_pkg::ST_RBINIT: st_d = flags_i.cnt_lt2 ? hq_pkg::ST_RDTOP : hq_pkg::ST_RBNEXT;
      hq_pkg::ST_RBNEXT: st_d = flags_i.idx_zero ? hq_pkg::ST_RDTOP : hq_pkg::ST_SDCHK;
      hq_pkg::ST_SDCHK:  st_d = flags_i.chd_gt_last ? hq_pkg::ST_RBNEXT : hq_pkg::ST_SDA;
      hq_pkg::ST_SDA:    st_d = hq_pkg::ST_SDB;
      hq_pkg::ST_SDB:    st_d = flags_i.chd_lt_last ? hq_pkg::ST_SDC : hq_pkg::ST_SDCMP;
      hq_pkg::ST_SDC:    st_d = hq_pkg::ST_SDPICK;
      hq_pkg::ST_SDPICK: st_d = hq_pkg::ST_SDCMP;
      hq_pkg::ST_SDCMP:  st_d = flags_i.dn_stop ? hq_pkg::ST_RBNEXT : hq_pkg::ST_DSW1;
      hq_pkg::ST_DSW1:   st_d = hq_pkg::ST_DSW2;
      hq_pkg::ST_DSW2:   st_d = hq_pkg::ST_SDCHK;
      hq_pkg::ST_SUCHK:  st_d = flags_i.cur_zero ? hq_pkg::ST_RDTOP : hq_pkg::ST_SUCAP;
      hq_pkg::ST_SUCAP:  st_d = hq_pkg::ST_SUCMP;
      hq_pkg::ST_SUCMP:  st_d = flags_i.up_stop ? hq_pkg::ST_RDTOP : hq_pkg::ST_USW1;
      hq_pkg::ST_USW1:   st_d = hq_pkg::ST_USW2;
      hq_pkg::ST_USW2:   st_d = hq_pkg::ST_SUCHK;
      hq_pkg::ST_RDTOP:  st_d = hq_pkg::ST_FIN;
      hq_pkg::ST_FIN:    if (!flags_i.out_busy) st_d = hq_pkg::ST_IDLE;
      default:           st_d = hq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = hq_pkg::OP_NONE;
    case (st_q)
      hq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = hq_pkg::OP_LOAD;
      end
      hq_pkg::ST_DISP: begin
        if (!flags_i.is_del) begin
          op_o = flags_i.full ? hq_pkg::OP_FULL : hq_pkg::OP_INS;
        end else if (flags_i.pos_bad) begin
          op_o = hq_pkg::OP_BAD;
        end else if (flags_i.pos_last) begin
          op_o = hq_pkg::OP_SHRINK;
        end else begin
          op_o = hq_pkg::OP_NONE;
        end
      end
      hq_pkg::ST_RDLAST: op_o = hq_pkg::OP_RD_LAST;
      hq_pkg::ST_MOVE:   op_o = hq_pkg::OP_MOVE;
      hq_pkg::ST_RBINIT: if (!flags_i.cnt_lt2) op_o = hq_pkg::OP_RB_INIT;
      hq_pkg::ST_RBNEXT: if (!flags_i.idx_zero) op_o = hq_pkg::OP_RB_NEXT;
      hq_pkg::ST_SDCHK:  if (!flags_i.chd_gt_last) op_o = hq_pkg::OP_RD_CUR;
      hq_pkg::ST_SDA:    op_o = hq_pkg::OP_CAPA_RDCHD;
      hq_pkg::ST_SDB:    op_o = flags_i.chd_lt_last ? hq_pkg::OP_CAPB_RDR : hq_pkg::OP_CAPB;
      hq_pkg::ST_SDC:    op_o = hq_pkg::OP_CAPC;
      hq_pkg::ST_SDPICK: op_o = hq_pkg::OP_PICK;
      hq_pkg::ST_DSW1:   op_o = hq_pkg::OP_SW1;
      hq_pkg::ST_DSW2:   op_o = hq_pkg::OP_SW2;
      hq_pkg::ST_SUCHK:  if (!flags_i.cur_zero) op_o = hq_pkg::OP_SU_RD;
      hq_pkg::ST_SUCAP:  op_o = hq_pkg::OP_CAPB;
      hq_pkg::ST_USW1:   op_o = hq_pkg::OP_SW1;
      hq_pkg::ST_USW2:   op_o = hq_pkg::OP_SW2;
      hq_pkg::ST_RDTOP:  op_o = hq_pkg::OP_RD_TOP;
      hq_pkg::ST_FIN:    if (!flags_i.out_busy) op_o = hq_pkg::OP_FIN;
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/indexed_min_heap_timestamp_queue_unit.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_timestamp_queue_unit: indexed min-heap of timed handles
// Insert with sift-up, delete with full bottom-up rebuild, handle slot map.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  beat
//  req_i    in   cmd, handle, key_sec, key_usec, position  valid & ready
//  rsp_o    out  status, count, top_*, handle_position     valid & ready
//  apb      in   heap_kind at byte address 0               psel&penable&pwrite
//
//  One item at a time. Insert writes the new entry at the end and swaps it up
//  level by level. Full insert, bad or last-slot delete go straight to the
//  result. Delete of an inner slot moves the last entry into it, then rebuilds
//  the heap bottom-up, sifting each inner node down. The single read port of
//  the slot memory allows one slot read per cycle.
//  Reset empties the heap and clears the map valid bits at once.
//  A pending result beat waits in the output register; the next item may be
//  taken meanwhile, but its result waits until that beat has been handed over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_min_heap_timestamp_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  hq_stream_if.sink         req_i,
  hq_stream_if.source       rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]     kind_q;
  logic           cfg_wr;
  hq_pkg::op_e    op;
  hq_pkg::flags_t flags;
  logic           in_ready;
  logic           out_valid;
  hq_pkg::rsp_t   out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, kind_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0;
    end else if (cfg_wr) begin
      kind_q <= pwdata[1:0];
    end
  end

  hq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .flags_i    (flags),
    .in_ready_o (in_ready),
    .op_o       (op)
  );

  hq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_q),
    .op_i        (op),
    .item_i      (req_i.payload),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .out_o       (out_data),
    .flags_o     (flags)
  );

  assign req_i.ready   = in_ready;
  assign rsp_o.valid   = out_valid;
  assign rsp_o.payload = out_data;

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("input taken again while an item is in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.payload.count <= hq_pkg::CAP_CNT)
    else $error("entry count beyond capacity");

  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.payload.top_valid == (rsp_o.payload.count != 7'd0))
    else $error("top_valid disagrees with count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.status == hq_pkg::STS_FULL
      |-> rsp_o.payload.count == hq_pkg::CAP_CNT)
    else $error("full status with room left");

endmodule
